@@ rtl/gch_pkg.sv @@
// Package for the grid change highlight block: payload types, codes and sizes.
package gch_pkg;

  localparam int GRID_W = 512;
  localparam int GRID_H = 512;
  localparam int XW = 9;
  localparam int YW = 9;
  localparam int AW = XW + YW;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    REQ_COMPARE = 2'd0,
    REQ_SYNC    = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_MIN_DELTA = 2'd0,
    CFG_HOLD      = 2'd1,
    CFG_FADE      = 2'd2,
    CFG_FULL_TRIG = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [8:0]        cell_x;
    logic [8:0]        cell_y;
    logic signed [7:0] cell_value;
    logic              is_update;
    logic [31:0]       now_ms;
    logic              frame_last;
  } in_item_t;

  typedef struct packed {
    logic       changed;
    logic [7:0] alpha;
    logic       box_valid;
    logic [8:0] box_min_x;
    logic [8:0] box_min_y;
    logic [8:0] box_max_x;
    logic [8:0] box_max_y;
  } out_item_t;

  // Classified work handed from the front end to the back end.
  typedef struct packed {
    req_t              req;
    logic              in_grid;
    logic              trig;
    logic [AW-1:0]     addr;
    logic [8:0]        x;
    logic [8:0]        y;
    logic signed [7:0] value;
    logic [31:0]       now;
    logic              last;
  } op_t;

endpackage

@@ rtl/gch_front.sv @@
// Front end: accepts items, classifies them and queues them for the back end.
module gch_front import gch_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     valid,
  output logic     stall,
  input  in_item_t in_item,
  input  logic     full_trig,
  output logic     op_valid,
  input  logic     op_take,
  output op_t      op
);

  op_t            q [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   cnt;
  logic           push, pop;
  op_t            cls;

  always_comb begin
    cls.req     = req_t'(in_item.req_type);
    cls.in_grid = ({1'b0, in_item.cell_x} < 10'(GRID_W)) &&
                  ({1'b0, in_item.cell_y} < 10'(GRID_H));
    cls.trig    = in_item.is_update | full_trig;
    cls.addr    = {in_item.cell_y, in_item.cell_x};
    cls.x       = in_item.cell_x;
    cls.y       = in_item.cell_y;
    cls.value   = in_item.cell_value;
    cls.now     = in_item.now_ms;
    cls.last    = in_item.frame_last;
  end

  assign stall    = (cnt == (QAW+1)'(QDEPTH));
  assign push     = valid && !stall;
  assign op_valid = (cnt != '0);
  assign pop      = op_valid && op_take;
  assign op       = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= cls;
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

@@ rtl/gch_divider.sv @@
// Sequential restoring divider for the fade rounding: 42-bit numerator by 33-bit divisor.
module gch_divider import gch_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [41:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [7:0]  quot
);

  logic [41:0] n;
  logic [33:0] rem;
  logic [32:0] d;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] trial;

  assign trial = {rem[32:0], n[41]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        n    <= num;
        d    <= den;
        rem  <= '0;
        cnt  <= 6'd42;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial;
          n   <= {n[40:0], 1'b1};
        end else begin
          rem <= {rem[32:0], n[41]};
          n   <= {n[40:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient never exceeds 255 when the divider is used.
  assign quot = n[7:0];

endmodule

@@ rtl/gch_back.sv @@
// Back end: cell and stamp memories, change test, bounding box and fade sequencer.
module gch_back import gch_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  output logic      op_take,
  input  op_t       op,
  input  logic [6:0]  min_delta,
  input  logic [15:0] hold_ms,
  input  logic [15:0] fade_ms,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EVAL, ST_SQ, ST_DIV, ST_OUT
  } bstate_t;

  logic signed [7:0] cells  [1 << AW];
  logic [31:0]       stamps [1 << AW];
  logic signed [7:0] cell_rd;
  logic [31:0]       stamp_rd;

  bstate_t    state, state_next;
  op_t        cur;
  out_item_t  res_next;
  logic [8:0] bmin_x, bmin_y, bmax_x, bmax_y;
  logic       bany;
  logic [31:0] age, dd;
  logic [15:0] r, f;
  logic [31:0] rr, ff;
  logic        div_start, div_done;
  logic [7:0]  div_q;
  logic        hit, stamp_wr;
  logic signed [8:0] diff;
  logic [8:0]  mag;

  assign op_take = (state == ST_IDLE) && !res_valid && op_valid;

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      cell_rd  <= cells[cur.addr];
      stamp_rd <= stamps[cur.addr];
    end
    if (state == ST_EVAL && cur.in_grid && cur.req != REQ_QUERY && cur.req != REQ_NONE)
      cells[cur.addr] <= cur.value;
    if (stamp_wr)
      stamps[cur.addr] <= (cur.req == REQ_SYNC) ? 32'd0 : cur.now;
  end

  always_comb begin
    diff = 9'(cur.value) - 9'(cell_rd);
    mag  = diff[8] ? 9'(-diff) : diff;
    hit  = cur.req == REQ_COMPARE && cur.in_grid && cur.trig && cell_rd != cur.value &&
           (cell_rd[7] || cur.value[7] || mag >= {2'b0, min_delta});
    stamp_wr = state == ST_EVAL && cur.in_grid && (hit || cur.req == REQ_SYNC);
    age = cur.now - stamp_rd;
    dd  = age - {16'd0, hold_ms};
    r   = fade_ms - dd[15:0];
    f   = fade_ms;
  end

  gch_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(42'({rr, 9'd0}) - 42'({rr, 1'b0}) + 42'(ff)),
    .den({ff, 1'b0}), .done(div_done), .quot(div_q)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    res_next   = res;
    case (state)
      ST_IDLE: if (op_take) state_next = ST_READ;
      ST_READ: state_next = ST_EVAL;
      ST_EVAL: begin
        res_next = '0;
        state_next = ST_OUT;
        if (cur.req == REQ_COMPARE) begin
          res_next.changed = hit;
          if (cur.last && (bany || hit)) begin
            res_next.box_valid = 1'b1;
            res_next.box_min_x = (hit && cur.x < bmin_x) ? cur.x : bmin_x;
            res_next.box_min_y = (hit && cur.y < bmin_y) ? cur.y : bmin_y;
            res_next.box_max_x = (hit && cur.x > bmax_x) ? cur.x : bmax_x;
            res_next.box_max_y = (hit && cur.y > bmax_y) ? cur.y : bmax_y;
          end
        end else if (cur.req == REQ_QUERY && cur.in_grid && stamp_rd != '0) begin
          if (age <= {16'd0, hold_ms}) res_next.alpha = 8'd255;
          else if (fade_ms != '0 && dd < {16'd0, fade_ms}) state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: if (div_done) begin
        res_next.alpha = div_q;
        state_next = ST_OUT;
      end
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (op_take) cur <= op;
    if (state == ST_EVAL) begin
      rr <= 32'(r) * 32'(r);
      ff <= 32'(f) * 32'(f);
    end
    res <= res_next;
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      bmin_x <= 9'd511; bmin_y <= 9'd511;
      bmax_x <= '0;     bmax_y <= '0;
      bany   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT) res_valid <= 1'b1;
      else if (res_valid && !res_stall) res_valid <= 1'b0;
      if (state == ST_EVAL && cur.req == REQ_COMPARE) begin
        if (cur.last) begin
          bmin_x <= 9'd511; bmin_y <= 9'd511;
          bmax_x <= '0;     bmax_y <= '0;
          bany   <= 1'b0;
        end else if (hit) begin
          if (cur.x < bmin_x) bmin_x <= cur.x;
          if (cur.y < bmin_y) bmin_y <= cur.y;
          if (cur.x > bmax_x) bmax_x <= cur.x;
          if (cur.y > bmax_y) bmax_y <= cur.y;
          bany <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/grid_change_highlight.sv @@
// Each accepted item passes the queue, then the READ, EVAL and OUT states of the back end.
// A query in its fade also passes SQ and waits in DIV on the 42-step serial divider.
// One item is in the back end at a time; a 4-entry queue decouples the input.
// The back end takes a new item only after the previous result has left.
// Synchronous reset clears control and the box and restores config defaults; memories stay undefined.
module grid_change_highlight import gch_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [6:0]  min_delta;
  logic [15:0] hold_ms, fade_ms;
  logic        full_trig;
  logic        op_valid, op_take;
  op_t         op;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_delta  <= 7'd1;
      hold_ms    <= 16'd50;
      fade_ms    <= 16'd350;
      full_trig  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_DELTA:  min_delta  <= cfg_data[6:0];
        CFG_HOLD:       hold_ms    <= cfg_data;
        CFG_FADE:       fade_ms    <= cfg_data;
        CFG_FULL_TRIG:  full_trig  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  gch_front u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .stall(in_stall), .in_item(in_data),
    .full_trig(full_trig), .op_valid(op_valid), .op_take(op_take), .op(op)
  );

  gch_back u_back (
    .clk(clk), .rst(rst), .op_valid(op_valid), .op_take(op_take), .op(op),
    .min_delta(min_delta), .hold_ms(hold_ms), .fade_ms(fade_ms),
    .res_valid(out_valid), .res_stall(out_stall), .res(out_data)
  );

endmodule

@@ bench/grid_change_highlight_test.sv @@
// Self-checking testbench for the grid change highlight block.
`timescale 1ns / 1ps

module grid_change_highlight_test;
  import gch_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int POOL_N = 48;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_MIN_DELTA;
  logic [15:0] cfg_data = '0;

  grid_change_highlight uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the block state.
  logic signed [7:0] shadow_mem [int];
  logic [31:0]       stamp_mem [int];
  logic [8:0]        box_lo_x, box_lo_y, box_hi_x, box_hi_y;
  logic              box_any;
  logic [6:0]        min_delta;
  logic [15:0]       hold_ms, fade_ms;
  logic              full_trig;

  out_item_t   pending_results[$];
  logic [8:0]  pool_x [POOL_N];
  logic [8:0]  pool_y [POOL_N];
  logic [31:0] clock_ms;
  bit          quiet = 0;
  int          errors = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] fade_level(logic [31:0] stamp, logic [31:0] now);
    logic [31:0] age, d;
    logic [63:0] f, r, num, den;
    if (stamp == 0) return 8'd0;
    age = now - stamp;
    if (age <= {16'd0, hold_ms}) return 8'd255;
    if (fade_ms == 0) return 8'd0;
    d = age - {16'd0, hold_ms};
    if (d >= {16'd0, fade_ms}) return 8'd0;
    f = fade_ms;
    r = f - d;
    num = 64'd510 * r * r + f * f;
    den = 64'd2 * f * f;
    return 8'(num / den);
  endfunction

  function automatic out_item_t predict_highlight(in_item_t it);
    out_item_t res;
    int idx, prev_val, after, mag;
    res = '0;
    idx = int'(it.cell_y) * GRID_W + int'(it.cell_x);
    after = int'(it.cell_value);
    case (req_t'(it.req_type))
      REQ_COMPARE: begin
        prev_val = int'(shadow_mem[idx]);
        if ((it.is_update || full_trig) && prev_val != after) begin
          mag = (after > prev_val) ? after - prev_val : prev_val - after;
          if (prev_val < 0 || after < 0 || mag >= int'(min_delta)) begin
            stamp_mem[idx] = it.now_ms;
            res.changed = 1'b1;
            if (it.cell_x < box_lo_x) box_lo_x = it.cell_x;
            if (it.cell_x > box_hi_x) box_hi_x = it.cell_x;
            if (it.cell_y < box_lo_y) box_lo_y = it.cell_y;
            if (it.cell_y > box_hi_y) box_hi_y = it.cell_y;
            box_any = 1'b1;
          end
        end
        shadow_mem[idx] = it.cell_value;
        if (it.frame_last) begin
          if (box_any) begin
            res.box_valid = 1'b1;
            res.box_min_x = box_lo_x;
            res.box_min_y = box_lo_y;
            res.box_max_x = box_hi_x;
            res.box_max_y = box_hi_y;
          end
          box_lo_x = 9'd511; box_lo_y = 9'd511;
          box_hi_x = 9'd0;   box_hi_y = 9'd0;
          box_any = 1'b0;
        end
      end
      REQ_SYNC: begin
        shadow_mem[idx] = it.cell_value;
        stamp_mem[idx] = 32'd0;
      end
      REQ_QUERY: res.alpha = fade_level(stamp_mem[idx], it.now_ms);
      default: ;
    endcase
    return res;
  endfunction

  // Leaves in_valid high on return; the next call or stop_input settles it.
  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), predict_highlight(it));
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Leaves cfg_we high on return; apply_setting drops it after the last write.
  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_MIN_DELTA:  min_delta = value[6:0];
      CFG_HOLD:       hold_ms = value;
      CFG_FADE:       fade_ms = value;
      default:        full_trig = value[0];
    endcase
  endtask

  task automatic apply_setting(logic [15:0] mc, logic [15:0] hold, logic [15:0] fade,
                               logic [15:0] ft);
    wait_drained();
    write_reg(CFG_MIN_DELTA, mc);
    write_reg(CFG_HOLD, hold);
    write_reg(CFG_FADE, fade);
    write_reg(CFG_FULL_TRIG, ft);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t cell_item(req_t req, int p, logic signed [7:0] value,
                                         logic upd, logic [31:0] now, logic last);
    in_item_t it;
    it.req_type = req;
    it.cell_x = pool_x[p];
    it.cell_y = pool_y[p];
    it.cell_value = value;
    it.is_update = upd;
    it.now_ms = now;
    it.frame_last = last;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int p, r, idx, old;
    logic [31:0] stamp;
    p = $urandom_range(0, POOL_N - 1);
    idx = int'(pool_y[p]) * GRID_W + int'(pool_x[p]);
    old = int'(shadow_mem[idx]);
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 29) == 0) clock_ms = $urandom() | 32'd1;
    else clock_ms = clock_ms + $urandom_range(0, 40);
    if (clock_ms == 0) clock_ms = 32'd1;
    it = random_cell_value(cell_item(REQ_COMPARE, p, 8'sd0, 1'($urandom_range(0, 1)),
                                     clock_ms, $urandom_range(0, 7) == 0), old);
    if (r < 30) begin
      it.req_type = REQ_QUERY;
      stamp = stamp_mem[idx];
      if (stamp != 0 && $urandom_range(0, 9) < 8)
        it.now_ms = stamp + $urandom_range(0, int'(hold_ms) + int'(fade_ms) + 30);
    end else if (r < 42) begin
      it.req_type = REQ_SYNC;
    end else if (r < 47) begin
      it.req_type = REQ_NONE;
      it.cell_x = 9'($urandom());
      it.cell_y = 9'($urandom());
      it.frame_last = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  function automatic in_item_t random_cell_value(in_item_t it, int old);
    int r, v;
    r = $urandom_range(0, 9);
    if (r < 4) v = old + $urandom_range(0, 12) - 6;
    else if (r < 9) v = $urandom_range(0, 101) - 1;
    else v = $urandom_range(0, 255) - 128;
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    it.cell_value = 8'(v);
    return it;
  endfunction

  task automatic test_sync_pool();
    pool_x[0] = 9'd0;   pool_y[0] = 9'd0;
    pool_x[1] = 9'd511; pool_y[1] = 9'd511;
    pool_x[2] = 9'd511; pool_y[2] = 9'd0;
    pool_x[3] = 9'd0;   pool_y[3] = 9'd511;
    for (int i = 4; i < POOL_N; i++) begin
      pool_x[i] = 9'($urandom());
      pool_y[i] = 9'($urandom());
    end
    for (int i = 0; i < POOL_N; i++)
      send_item(cell_item(REQ_SYNC, i, 8'sd50, 1'($urandom_range(0, 1)), $urandom(),
                          1'($urandom_range(0, 1))));
  endtask

  task automatic test_directed();
    // Reset settings: min change 1, hold 50, fade 350, updates only.
    send_item(cell_item(REQ_COMPARE, 0, 8'sd100, 1'b1, 32'd1000, 1'b0));
    send_item(cell_item(REQ_COMPARE, 1, -8'sd1, 1'b1, 32'd1001, 1'b1));
    send_item(cell_item(REQ_COMPARE, 2, 8'sd0, 1'b0, 32'd1002, 1'b1));
    send_item(cell_item(REQ_QUERY, 0, 8'sd0, 1'b0, 32'd1050, 1'b0));
    send_item(cell_item(REQ_QUERY, 0, 8'sd0, 1'b0, 32'd1051, 1'b0));
    send_item(cell_item(REQ_QUERY, 0, 8'sd0, 1'b0, 32'd1225, 1'b0));
    send_item(cell_item(REQ_QUERY, 0, 8'sd0, 1'b0, 32'd1399, 1'b0));
    send_item(cell_item(REQ_QUERY, 0, 8'sd0, 1'b0, 32'd1400, 1'b0));
    // An age that wraps past zero reads as a huge age.
    send_item(cell_item(REQ_QUERY, 1, 8'sd0, 1'b0, 32'd5, 1'b0));
    send_item(cell_item(REQ_QUERY, 2, 8'sd0, 1'b0, 32'hFFFF_FFFF, 1'b0));
    send_item(cell_item(REQ_SYNC, 0, 8'sd127, 1'b0, 32'd1500, 1'b0));
    send_item(cell_item(REQ_QUERY, 0, 8'sd0, 1'b0, 32'd1500, 1'b0));
    // Negative values always count as a change; an unchanged value never counts.
    send_item(cell_item(REQ_COMPARE, 0, -8'sd128, 1'b1, 32'd1600, 1'b0));
    send_item(cell_item(REQ_COMPARE, 3, 8'sd50, 1'b1, 32'd1601, 1'b0));
    send_item(cell_item(REQ_COMPARE, 3, 8'sd51, 1'b1, 32'd1602, 1'b1));
    // Stamping with time zero leaves the cell reading as unstamped.
    send_item(cell_item(REQ_COMPARE, 4, 8'sd0, 1'b1, 32'd0, 1'b1));
    send_item(cell_item(REQ_QUERY, 4, 8'sd0, 1'b0, 32'd10, 1'b0));
    send_item(cell_item(REQ_NONE, 5, 8'sd7, 1'b1, 32'hFFFF_FFFF, 1'b1));
    send_item(cell_item(REQ_SYNC, 4, -8'sd1, 1'b1, 32'd1, 1'b1));
    send_item(cell_item(REQ_QUERY, 3, 8'sd0, 1'b1, 32'd1602, 1'b1));
    clock_ms = 32'd2000;
  endtask

  task automatic test_settings();
    logic [15:0] mc [6] = '{16'd0, 16'd100, 16'd127, 16'd1, 16'd5, 16'd20};
    logic [15:0] hd [6] = '{16'd3, 16'd0, 16'd65535, 16'd0, 16'd10, 16'd40};
    logic [15:0] fd [6] = '{16'd20, 16'd0, 16'd1, 16'd65535, 16'd100, 16'd300};
    logic [15:0] ft [6] = '{16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd0};
    for (int s = 0; s < 6; s++) begin
      apply_setting(mc[s], hd[s], fd[s], ft[s]);
      quiet = (s == 3);
      for (int n = 0; n < 150; n++) send_item(random_item());
    end
    quiet = 0;
  endtask

  initial begin
    box_lo_x = 9'd511; box_lo_y = 9'd511; box_hi_x = 9'd0; box_hi_y = 9'd0;
    box_any = 1'b0;
    min_delta = 7'd1; hold_ms = 16'd50; fade_ms = 16'd350; full_trig = 1'b0;
    clock_ms = 32'd1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_sync_pool();
    test_directed();
    test_settings();
    stop_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver stall pattern: mostly short, now and then long.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending: %p", $realtime, out_data);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_data.changed !== want.changed) begin
          errors++;
          $display("%0t: changed want %0d got %0d", $realtime, want.changed, out_data.changed);
        end
        if (out_data.alpha !== want.alpha) begin
          errors++;
          $display("%0t: alpha want %0d got %0d", $realtime, want.alpha, out_data.alpha);
        end
        if (out_data.box_valid !== want.box_valid) begin
          errors++;
          $display("%0t: box_valid want %0d got %0d", $realtime, want.box_valid,
                   out_data.box_valid);
        end
        if (out_data.box_min_x !== want.box_min_x || out_data.box_min_y !== want.box_min_y ||
            out_data.box_max_x !== want.box_max_x || out_data.box_max_y !== want.box_max_y) begin
          errors++;
          $display("%0t: box want %0d,%0d..%0d,%0d got %0d,%0d..%0d,%0d", $realtime,
                   want.box_min_x, want.box_min_y, want.box_max_x, want.box_max_y,
                   out_data.box_min_x, out_data.box_min_y, out_data.box_max_x,
                   out_data.box_max_y);
        end
      end
    end
  end

  // Watchdog on cycles where neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (out_valid && !out_stall) || (in_valid && !in_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ grid_change_highlight.f @@
rtl/gch_pkg.sv
rtl/gch_front.sv
rtl/gch_divider.sv
rtl/gch_back.sv
rtl/grid_change_highlight.sv
bench/grid_change_highlight_test.sv
